// ===== rtl/u8cp_pkg.sv =====
`default_nettype none

package u8cp_pkg;

   // Codepoint reported for the end of the stream.
   localparam logic signed [21:0] EOS_CODEPOINT = -22'sd1;

   // Replacement character for the undefined Windows-1252 slots.
   localparam logic [15:0] REPL_CHAR = 16'hFFFD;

   // Byte class boundaries.
   localparam logic [7:0] ASCII_LIMIT   = 8'h80;
   localparam logic [7:0] LEAD_LOW_EXCL = 8'hC1;
   localparam logic [7:0] LEAD_HI_EXCL  = 8'hF5;
   localparam logic [7:0] LEAD_THREE    = 8'hE0;
   localparam logic [7:0] LEAD_FOUR     = 8'hF0;
   localparam logic [7:0] LEAD_MAX      = 8'hF4;
   localparam logic [7:0] E0_SECOND_MIN = 8'h9F;
   localparam logic [7:0] F0_SECOND_MIN = 8'h8F;
   localparam logic [7:0] F4_SECOND_MAX = 8'h90;
   localparam logic [7:0] CONT_MASK     = 8'hC0;
   localparam logic [7:0] CONT_TAG      = 8'h80;

   // One queued job: the held bytes to dump first, then a final codepoint.
   typedef struct packed {
      logic [2:0][7:0]    held;
      logic [1:0]         held_count;
      logic [2:0]         group_bytes;
      logic               is_fallback;
      logic signed [21:0] tail_cp;
   } job_type;

   // Windows-1252 mapping; bytes below 0x80 and from 0xA0 map to themselves.
   function automatic logic [21:0] map_byte(input logic [7:0] b);
      logic [15:0] cp;
      begin
         case (b)
            8'h80: cp = 16'h20AC;
            8'h82: cp = 16'h201A;
            8'h83: cp = 16'h0192;
            8'h84: cp = 16'h201E;
            8'h85: cp = 16'h2026;
            8'h86: cp = 16'h2020;
            8'h87: cp = 16'h2021;
            8'h88: cp = 16'h02C6;
            8'h89: cp = 16'h2030;
            8'h8A: cp = 16'h0160;
            8'h8B: cp = 16'h2039;
            8'h8C: cp = 16'h0152;
            8'h8E: cp = 16'h017D;
            8'h91: cp = 16'h2018;
            8'h92: cp = 16'h2019;
            8'h93: cp = 16'h201C;
            8'h94: cp = 16'h201D;
            8'h95: cp = 16'h2022;
            8'h96: cp = 16'h2013;
            8'h97: cp = 16'h2014;
            8'h98: cp = 16'h02DC;
            8'h99: cp = 16'h2122;
            8'h9A: cp = 16'h0161;
            8'h9B: cp = 16'h203A;
            8'h9C: cp = 16'h0153;
            8'h9E: cp = 16'h017E;
            8'h9F: cp = 16'h0178;
            8'h81, 8'h8D, 8'h8F, 8'h90, 8'h9D: cp = REPL_CHAR;
            default: cp = {8'h00, b};
         endcase
         return {6'd0, cp};
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/u8cp_req_if.sv =====
`default_nettype none

interface u8cp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

// ===== rtl/u8cp_rsp_if.sv =====
`default_nettype none

interface u8cp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [21:0] codepoint;
   logic [2:0]         group_bytes;
   logic               is_fallback;
   logic               last_of_group;

   modport source (output valid, output codepoint, output group_bytes,
                   output is_fallback, output last_of_group, input ready);
   modport sink (input valid, input codepoint, input group_bytes,
                 input is_fallback, input last_of_group, output ready);
endinterface

`default_nettype wire

// ===== rtl/u8cp_front.sv =====
`default_nettype none

module u8cp_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    accept,
   input  wire  [7:0]             data_byte,
   input  wire                    end_of_stream,
   output logic                   push,
   output u8cp_pkg::job_type      job
);

   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      count_ff, count_in;
   logic [2:0]      exp_ff, exp_in;

   logic            cont_ok;
   logic [2:0]      seq_len;
   logic [20:0]     decoded;
   logic            want_job;

   // Continuation check, with the second-byte range rules after E0, F0 and F4.
   always_comb begin
      cont_ok = (data_byte & u8cp_pkg::CONT_MASK) == u8cp_pkg::CONT_TAG;
      if (count_ff == 2'd1) begin
         if (held_ff[0] == u8cp_pkg::LEAD_THREE && !(data_byte > u8cp_pkg::E0_SECOND_MIN))
            cont_ok = 1'b0;
         if (held_ff[0] == u8cp_pkg::LEAD_FOUR && !(data_byte > u8cp_pkg::F0_SECOND_MIN))
            cont_ok = 1'b0;
         if (held_ff[0] == u8cp_pkg::LEAD_MAX && !(data_byte < u8cp_pkg::F4_SECOND_MAX))
            cont_ok = 1'b0;
      end
   end

   // Once the tag bits are checked, the codepoint is the concatenated payload bits.
   always_comb begin
      seq_len = {1'b0, count_ff} + 3'd1;
      case (count_ff)
         2'd1:    decoded = {10'd0, held_ff[0][4:0], data_byte[5:0]};
         2'd2:    decoded = {5'd0, held_ff[0][3:0], held_ff[1][5:0], data_byte[5:0]};
         default: decoded = {held_ff[0][2:0], held_ff[1][5:0], held_ff[2][5:0],
                             data_byte[5:0]};
      endcase
   end

   // Classification of the accepted word and the job it issues.
   always_comb begin
      held_in              = held_ff;
      count_in             = count_ff;
      exp_in               = exp_ff;
      want_job             = 1'b1;
      job.held             = held_ff;
      job.held_count       = 2'd0;
      job.group_bytes      = 3'd1;
      job.is_fallback      = 1'b0;
      job.tail_cp          = u8cp_pkg::EOS_CODEPOINT;
      if (end_of_stream) begin
         if (count_ff != 2'd0) begin
            job.held_count  = count_ff;
            job.group_bytes = seq_len;
            job.is_fallback = 1'b1;
         end
         count_in = 2'd0;
         exp_in   = 3'd0;
      end else if (count_ff == 2'd0) begin
         if (data_byte < u8cp_pkg::ASCII_LIMIT) begin
            job.tail_cp = {14'd0, data_byte};
         end else if (data_byte > u8cp_pkg::LEAD_LOW_EXCL &&
                      data_byte < u8cp_pkg::LEAD_HI_EXCL) begin
            want_job   = 1'b0;
            held_in[0] = data_byte;
            count_in   = 2'd1;
            if (data_byte < u8cp_pkg::LEAD_THREE)
               exp_in = 3'd2;
            else if (data_byte < u8cp_pkg::LEAD_FOUR)
               exp_in = 3'd3;
            else
               exp_in = 3'd4;
         end else begin
            job.tail_cp     = u8cp_pkg::map_byte(data_byte);
            job.is_fallback = 1'b1;
         end
      end else if (!cont_ok) begin
         job.held_count  = count_ff;
         job.group_bytes = seq_len;
         job.is_fallback = 1'b1;
         job.tail_cp     = u8cp_pkg::map_byte(data_byte);
         count_in        = 2'd0;
         exp_in          = 3'd0;
      end else if (seq_len >= exp_ff) begin
         job.group_bytes = seq_len;
         job.tail_cp     = {1'b0, decoded};
         count_in        = 2'd0;
         exp_in          = 3'd0;
      end else begin
         want_job = 1'b0;
         case (count_ff)
            2'd1:    held_in[1] = data_byte;
            default: held_in[2] = data_byte;
         endcase
         count_in = count_ff + 2'd1;
      end
   end

   assign push = accept && want_job;

   // Sequence state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         exp_ff   <= 3'd0;
      end else if (accept) begin
         count_ff <= count_in;
         exp_ff   <= exp_in;
      end
   end

   // Held bytes need no reset; only entries of the open sequence are read.
   always_ff @(posedge clock) begin
      if (accept)
         held_ff <= held_in;
   end

endmodule

`default_nettype wire

// ===== rtl/u8cp_queue.sv =====
`default_nettype none

module u8cp_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  wire u8cp_pkg::job_type push_job,
   output logic                   full,
   input  wire                    pop,
   output logic                   not_empty,
   output u8cp_pkg::job_type      head_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   u8cp_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign full      = cnt_ff == FULL_CNT;
   assign not_empty = cnt_ff != '0;
   assign head_job  = slot_ff[rd_ff];

   // Pointer and fill updates.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push)
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      if (pop)
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      if (push && !pop)
         cnt_in = cnt_ff + CNT_W'(1);
      else if (pop && !push)
         cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ff] <= push_job;
   end

endmodule

`default_nettype wire

// ===== rtl/u8cp_back.sv =====
`default_nettype none

module u8cp_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    job_valid,
   input  wire u8cp_pkg::job_type job,
   output logic                   pop,
   u8cp_rsp_if.source             rsp_chan
);

   logic [1:0]  idx_ff, idx_in;
   logic        last;
   logic [7:0]  held_sel;

   assign last = idx_ff == job.held_count;

   // Pick the held byte for the current result.
   always_comb begin
      case (idx_ff)
         2'd0:    held_sel = job.held[0];
         2'd1:    held_sel = job.held[1];
         default: held_sel = job.held[2];
      endcase
   end

   // Result word: held bytes first, then the final codepoint.
   assign rsp_chan.valid         = job_valid;
   assign rsp_chan.codepoint     = last ? job.tail_cp : u8cp_pkg::map_byte(held_sel);
   assign rsp_chan.group_bytes   = job.group_bytes;
   assign rsp_chan.is_fallback   = job.is_fallback;
   assign rsp_chan.last_of_group = last;

   assign pop = job_valid && rsp_chan.ready && last;

   // Result index within the current job.
   always_comb begin
      idx_in = idx_ff;
      if (job_valid && rsp_chan.ready)
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         idx_ff <= 2'd0;
      else
         idx_ff <= idx_in;
   end

endmodule

`default_nettype wire

// ===== rtl/utf8_decode_cp1252_fallback_top.sv =====
// UTF-8 decoder with Windows-1252 fallback.
// The req_chan channel takes one byte word per cycle (data_byte) while the
// queue is not full, or an end of stream marker (end_of_stream). The rsp_chan
// channel returns codepoint words with group_bytes, is_fallback and
// last_of_group; a word is moved when valid and ready are both high.
// The front classifies each byte and keeps the open sequence; every byte that
// closes a group, and every end of stream marker, posts a job to a queue of
// QUEUE_DEPTH entries, and the back turns each job into one to four result
// words, one word per cycle while rsp_chan.ready is high. Each job is
// registered in the queue before the back presents its first result word.
// Throughput is one byte per cycle while groups produce one word each; an
// invalid group gives extra words at the back, which the queue absorbs until it fills.
// req_chan.ready is low only while the queue is full, so a stalled receiver
// holds its current word and stops input once QUEUE_DEPTH jobs are waiting.
// Synchronous reset empties the queue and closes any open sequence.
`default_nettype none

module utf8_decode_cp1252_fallback_top #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire         clock,
   input  wire         reset,
   u8cp_req_if.sink    req_chan,
   u8cp_rsp_if.source  rsp_chan
);

   u8cp_pkg::job_type push_job, head_job;
   logic              push, pop, full, not_empty, accept;

   assign req_chan.ready = !full;
   assign accept         = req_chan.valid && !full;

   u8cp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_chan.data_byte),
      .end_of_stream (req_chan.end_of_stream),
      .push          (push),
      .job           (push_job)
   );

   u8cp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_job  (head_job)
   );

   u8cp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (not_empty),
      .job       (head_job),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
